// File: rtl/core/sfgp_pkg.sv
// ----------------------------------------------------------------------------
// sfgp_pkg: shared types and constants for the stroke font glyph plotter
// Table geometry, action and register codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package sfgp_pkg;

   localparam int TABLE_ROWS  = 2048;
   localparam int ADDR_W      = $clog2(TABLE_ROWS);
   localparam int IDX_W       = ADDR_W + 1;
   localparam int ROW_W       = 18;
   localparam int MAX_STROKES = 64;
   localparam int CNT_W       = $clog2(MAX_STROKES + 1);

   // ceil(2^16 / 9): exact floor(m/9) for m below 2^14
   localparam logic [12:0] RECIP_NINTH = 13'd7282;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_WORD = 2'd1;
   localparam logic [1:0] ACT_CHAR = 2'd2;

   localparam logic [1:0] REG_HEIGHT = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_ROWS   = 2'd2;

   typedef struct packed {
      logic       marker;
      logic [7:0] first;
      logic [7:0] second;
      logic       pen;
   } row_type;

   typedef struct packed {
      logic req_ready;
      logic scan_clr;
      logic scan_inc;
      logic row_ld;
      logic offs;
      logic word;
      logic mul;
      logic div;
      logic fin;
      logic push;
      logic last;
      logic col_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] action;
      logic       scan_end;
      logic       row_marker;
      logic       code_match;
      logic       rsp_free;
   } dp_sts_type;

endpackage

// File: rtl/core/sfgp_if.sv
// ----------------------------------------------------------------------------
// sfgp_if: channel interfaces of the stroke font glyph plotter
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfgp_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [10:0]       row_index;
   logic              row_is_marker;
   logic signed [7:0] row_first;
   logic signed [7:0] row_second;
   logic              row_pen;
   logic [6:0]        letter_count;
   logic [7:0]        char_code;

   modport source(output valid, action, row_index, row_is_marker, row_first,
                  row_second, row_pen, letter_count, char_code, input ready);
   modport sink(input valid, action, row_index, row_is_marker, row_first,
                row_second, row_pen, letter_count, char_code, output ready);
endinterface

interface sfgp_rsp_if;
   logic               valid;
   logic               ready;
   logic               pen_down;
   logic signed [15:0] x_tenths;
   logic signed [18:0] y_tenths;
   logic               last_move;

   modport source(output valid, pen_down, x_tenths, y_tenths, last_move, input ready);
   modport sink(input valid, pen_down, x_tenths, y_tenths, last_move, output ready);
endinterface

interface sfgp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [11:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/stroke_font_glyph_plotter.sv
// ----------------------------------------------------------------------------
// stroke_font_glyph_plotter: single-stroke font text plotter
//
//   channel  dir  handshake    payload
//   req_ch   in   valid/ready  action, row fields, letter_count, char_code
//   rsp_ch   out  valid/ready  pen_down, x_tenths, y_tenths, last_move
//   csr_ch   in   valid/ready  index, data (ready always high)
//
// Load items are written straight into the font table; start-word items pass
// through the wrap state S_WORD. A character item scans the font table RAM row
// by row up to the glyph end and runs S_MUL, S_DIV and S_FIN per stroke emitted.
// A busy output register stalls the scan until it is taken.
// Synchronous reset; the font table RAM is not cleared.
// ----------------------------------------------------------------------------
module stroke_font_glyph_plotter (
   input  logic       clock,
   input  logic       reset,
   sfgp_req_if.sink   req_ch,
   sfgp_rsp_if.source rsp_ch,
   sfgp_csr_if.sink   csr_ch
);
   import sfgp_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sfgp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   sfgp_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .sts    (sts)
   );
endmodule

// File: rtl/core/sfgp_ram.sv
// ----------------------------------------------------------------------------
// sfgp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfgp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/sfgp_dp.sv
// ----------------------------------------------------------------------------
// sfgp_dp: datapath of the stroke font glyph plotter
// Registers, font table, scan index, coordinate arithmetic, output register.
// ----------------------------------------------------------------------------
module sfgp_dp (
   input  logic                 clock,
   input  logic                 reset,
   sfgp_req_if.sink             req_ch,
   sfgp_rsp_if.source           rsp_ch,
   sfgp_csr_if.sink             csr_ch,
   input  sfgp_pkg::dp_cmd_type cmd,
   output sfgp_pkg::dp_sts_type sts
);
   import sfgp_pkg::*;

   logic [3:0]       h_ff;
   logic [9:0]       lw_ff;
   logic [11:0]      rows_ff;
   logic [7:0]       col_ff;
   logic [9:0]       line_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [6:0]       letters_ff;
   logic [7:0]       code_ff;
   row_type          row_ff;
   logic [13:0]      mx_ff, my_ff;
   logic             sx_ff, sy_ff;
   logic [10:0]      qx_ff, qy_ff;
   logic [16:0]      xoff_ff;
   logic [18:0]      yoff_ff;
   logic             pen_ff;
   logic signed [15:0] px_ff;
   logic signed [18:0] py_ff;
   logic             rsp_valid_ff;
   logic             rsp_pen_ff, rsp_last_ff;
   logic signed [15:0] rsp_x_ff;
   logic signed [18:0] rsp_y_ff;

   row_type          rd_row;
   logic [ROW_W-1:0] rd_data;
   logic             accept;
   logic [7:0]       abs_x, abs_y;
   logic [11:0]      mag_x, mag_y;
   logic [26:0]      prod_x, prod_y;
   logic [11:0]      col_h;
   logic [10:0]      letters_h;
   logic [14:0]      pitch_h;
   logic [12:0]      extent;
   logic signed [17:0] x_q, x_sum;
   logic signed [20:0] y_q, y_sum;
   logic signed [15:0] x_sat;
   logic signed [18:0] y_sat;

   assign accept = req_ch.valid && cmd.req_ready;
   assign req_ch.ready = cmd.req_ready;
   assign csr_ch.ready = 1'b1;

   sfgp_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ROWS)) u_font (
      .clock   (clock),
      .wr_en   (accept && req_ch.action == ACT_LOAD),
      .wr_addr (req_ch.row_index),
      .wr_data ({req_ch.row_is_marker, req_ch.row_first, req_ch.row_second,
                 req_ch.row_pen}),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );
   assign rd_row = row_type'(rd_data);

   always_comb begin
      abs_x     = row_ff.first[7] ? 8'(-row_ff.first) : row_ff.first;
      abs_y     = row_ff.second[7] ? 8'(-row_ff.second) : row_ff.second;
      mag_x     = abs_x * h_ff;
      mag_y     = abs_y * h_ff;
      prod_x    = mx_ff * RECIP_NINTH;
      prod_y    = my_ff * RECIP_NINTH;
      col_h     = col_ff * h_ff;
      letters_h = letters_ff * h_ff;
      pitch_h   = {line_ff, 1'b1} * h_ff;
      extent    = 13'(col_h) + 13'(letters_h);

      x_q   = sx_ff ? -$signed({7'b0, qx_ff}) : $signed({7'b0, qx_ff});
      x_sum = x_q + $signed({1'b0, xoff_ff});
      if (x_sum > 18'sd32767) begin
         x_sat = 16'sh7FFF;
      end else if (x_sum < -18'sd32768) begin
         x_sat = 16'sh8000;
      end else begin
         x_sat = x_sum[15:0];
      end

      y_q   = sy_ff ? -$signed({10'b0, qy_ff}) : $signed({10'b0, qy_ff});
      y_sum = y_q - $signed({2'b0, yoff_ff});
      if (y_sum > 21'sd262143) begin
         y_sat = 19'sh3FFFF;
      end else if (y_sum < -21'sd262144) begin
         y_sat = 19'sh40000;
      end else begin
         y_sat = y_sum[18:0];
      end
   end

   always_comb begin
      sts.accept     = accept;
      sts.action     = req_ch.action;
      sts.scan_end   = (idx_ff >= rows_ff) || (idx_ff >= IDX_W'(TABLE_ROWS));
      sts.row_marker = rd_row.marker;
      sts.code_match = rd_row.second == code_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff         <= 4'd4;
         lw_ff        <= 10'd100;
         rows_ff      <= '0;
         col_ff       <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               REG_HEIGHT: h_ff    <= csr_ch.data[3:0];
               REG_WIDTH:  lw_ff   <= csr_ch.data[9:0];
               REG_ROWS:   rows_ff <= csr_ch.data;
               default: ;
            endcase
         end
         if (cmd.word && extent > 13'(lw_ff)) begin
            col_ff <= '0;
            if (line_ff != 10'h3FF) begin
               line_ff <= line_ff + 10'd1;
            end
         end
         if (cmd.col_inc && col_ff != 8'hFF) begin
            col_ff <= col_ff + 8'd1;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         letters_ff <= req_ch.letter_count;
         code_ff    <= req_ch.char_code;
      end
      if (cmd.scan_clr) begin
         idx_ff <= '0;
      end else if (cmd.scan_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.row_ld) begin
         row_ff <= rd_row;
      end
      if (cmd.offs) begin
         xoff_ff <= 17'({col_h, 3'b0}) + 17'({col_h, 1'b0});
         yoff_ff <= 19'({pitch_h, 3'b0}) + 19'({pitch_h, 1'b0});
      end
      if (cmd.mul) begin
         // |v*h*5| + 4, rounding bias before the divide by nine
         mx_ff <= 14'({mag_x, 2'b0}) + 14'(mag_x) + 14'd4;
         my_ff <= 14'({mag_y, 2'b0}) + 14'(mag_y) + 14'd4;
         sx_ff <= row_ff.first[7];
         sy_ff <= row_ff.second[7];
      end
      if (cmd.div) begin
         qx_ff <= prod_x[26:16];
         qy_ff <= prod_y[26:16];
      end
      if (cmd.fin) begin
         pen_ff <= row_ff.pen;
         px_ff  <= x_sat;
         py_ff  <= y_sat;
      end
      if (cmd.push) begin
         rsp_pen_ff  <= pen_ff;
         rsp_x_ff    <= px_ff;
         rsp_y_ff    <= py_ff;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pen_down  = rsp_pen_ff;
   assign rsp_ch.x_tenths  = rsp_x_ff;
   assign rsp_ch.y_tenths  = rsp_y_ff;
   assign rsp_ch.last_move = rsp_last_ff;

`ifndef SYNTHESIS
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> sts.rsp_free) else $error("push into occupied output register");
`endif
endmodule

// File: rtl/core/sfgp_ctrl.sv
// ----------------------------------------------------------------------------
// sfgp_ctrl: controller of the stroke font glyph plotter
// Sequences word wrap, table scan, stroke arithmetic and result hand-off.
// ----------------------------------------------------------------------------
module sfgp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  sfgp_pkg::dp_sts_type sts,
   output sfgp_pkg::dp_cmd_type cmd
);
   import sfgp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_WORD, S_OFFS, S_ADDR, S_EVAL, S_PUSH, S_MUL, S_DIV, S_FIN,
      S_TERM, S_ADV
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             found_ff, found_in;
   logic             pend_ff, pend_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.accept) begin
               if (sts.action == ACT_WORD) begin
                  state_in = S_WORD;
               end else if (sts.action == ACT_CHAR) begin
                  cmd.scan_clr = 1'b1;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  pend_in  = 1'b0;
                  state_in = S_OFFS;
               end
            end
         end
         S_WORD: begin
            cmd.word = 1'b1;
            state_in = S_IDLE;
         end
         S_OFFS: begin
            cmd.offs = 1'b1;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            state_in = sts.scan_end ? S_TERM : S_EVAL;
         end
         S_EVAL: begin
            cmd.row_ld   = 1'b1;
            cmd.scan_inc = 1'b1;
            state_in     = S_ADDR;
            if (!found_ff) begin
               if (sts.row_marker && sts.code_match) begin
                  found_in = 1'b1;
               end
            end else if (sts.row_marker) begin
               state_in = S_TERM;
            end else if (cnt_ff != CNT_W'(MAX_STROKES)) begin
               state_in = pend_ff ? S_PUSH : S_MUL;
            end
         end
         S_PUSH: begin
            // a newer stroke exists, so the held one is not the last
            if (sts.rsp_free) begin
               cmd.push = 1'b1;
               pend_in  = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            pend_in  = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = S_ADDR;
         end
         S_TERM: begin
            if (!pend_ff) begin
               state_in = S_ADV;
            end else if (sts.rsp_free) begin
               cmd.push = 1'b1;
               cmd.last = 1'b1;
               pend_in  = 1'b0;
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd.col_inc = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
         pend_ff  <= pend_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_STROKES)) else $error("stroke count past limit");
   a_pend_found: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> found_ff) else $error("stroke held without a glyph");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && cmd.last) |=> !pend_ff && state_ff == S_ADV)
      else $error("final stroke hand-off left state behind");
`endif
endmodule
